// ===== hdl/svpwm_duty_compare_gen_unit_defines.svh =====
// Assertion helpers used by the top-level file to check the SVPWM generator.
// Each helper expects clk and arst_n to be visible where it is used.
`ifndef SVPWM_DUTY_COMPARE_GEN_UNIT_DEFINES_SVH
`define SVPWM_DUTY_COMPARE_GEN_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVPWM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/svpwm_pkg.sv =====
package svpwm_pkg;

	// Fixed-point format and field widths.
	localparam int FRAC_BITS = 24;
	localparam int WORD_W    = 32;
	localparam int DUTY_W    = FRAC_BITS + 1;
	localparam int HP_W      = 16;
	localparam int CMP_W     = 16;
	localparam int SECTOR_W  = 3;
	localparam int COEF_W    = FRAC_BITS + 2;
	localparam int CFG_IDX_W = 3;

	// Queue between front and back, and the result queue. Depths are powers of two.
	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = FQ_PTR_W + 1;
	localparam int OQ_DEPTH = 16;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	// Unity in the working format and in the duty format.
	localparam logic [WORD_W-1:0] ONE_Q    = WORD_W'(64'd1 << FRAC_BITS);
	localparam logic [DUTY_W-1:0] DUTY_ONE = DUTY_W'(64'd1 << FRAC_BITS);

	// Sector numbers.
	localparam logic [SECTOR_W-1:0] SECTOR_0   = SECTOR_W'(0);
	localparam logic [SECTOR_W-1:0] SECTOR_1   = SECTOR_W'(1);
	localparam logic [SECTOR_W-1:0] SECTOR_2   = SECTOR_W'(2);
	localparam logic [SECTOR_W-1:0] SECTOR_3   = SECTOR_W'(3);
	localparam logic [SECTOR_W-1:0] SECTOR_4   = SECTOR_W'(4);
	localparam logic [SECTOR_W-1:0] SECTOR_5   = SECTOR_W'(5);
	localparam logic [SECTOR_W-1:0] SECTOR_MAX = SECTOR_5;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DC_GAIN     = 3'd0,
		REG_OFFSET_A    = 3'd1,
		REG_OFFSET_B    = 3'd2,
		REG_OFFSET_C    = 3'd3,
		REG_HALF_PERIOD = 3'd4
	} cfg_reg_t;

	// Configuration as seen by the datapath; the gain is held as its magnitude.
	typedef struct packed {
		logic [WORD_W-1:0] gain_abs;
		logic [WORD_W-1:0] offset_a;
		logic [WORD_W-1:0] offset_b;
		logic [WORD_W-1:0] offset_c;
		logic [HP_W-1:0]   half_period;
	} cfg_regs_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic [WORD_W-1:0]   ag;
		logic [WORD_W-1:0]   bg;
		logic [SECTOR_W-1:0] sector;
		logic                stop;
	} fq_item_t;

	// Queue status seen by the consumer.
	typedef struct packed {
		logic     valid;
		fq_item_t head;
	} fq_stat_t;

	// Per-sector coefficients for T1 (c0, c1) and T2 (c2, c3).
	typedef struct packed {
		logic signed [COEF_W-1:0] c0;
		logic signed [COEF_W-1:0] c1;
		logic signed [COEF_W-1:0] c2;
		logic signed [COEF_W-1:0] c3;
	} coef_set_t;

	// One finished result.
	typedef struct packed {
		logic [DUTY_W-1:0]   duty_a;
		logic [DUTY_W-1:0]   duty_b;
		logic [DUTY_W-1:0]   duty_c;
		logic [CMP_W-1:0]    compare_a;
		logic [CMP_W-1:0]    compare_b;
		logic [CMP_W-1:0]    compare_c;
		logic [SECTOR_W-1:0] sector;
		logic                enabled;
	} out_item_t;

	// Integer square root, used only to build the constants below.
	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bits;
		rem  = n;
		root = '0;
		bits = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bits > rem) begin
				bits = bits >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (bits != 64'd0) begin
				if (rem >= root + bits) begin
					rem  = rem - (root + bits);
					root = (root >> 1) + bits;
				end else begin
					root = root >> 1;
				end
				bits = bits >> 2;
			end
		end
		return root;
	endfunction

	// sqrt(3/2), sqrt(1/2) and sqrt(2), truncated to FRAC_BITS fraction bits.
	localparam logic signed [COEF_W-1:0] K_SQ32 =
		COEF_W'(isqrt64(64'd3 << (2 * FRAC_BITS - 1)));
	localparam logic signed [COEF_W-1:0] K_SQH =
		COEF_W'(isqrt64(64'd1 << (2 * FRAC_BITS - 1)));
	localparam logic signed [COEF_W-1:0] K_SQ2 =
		COEF_W'(isqrt64(64'd1 << (2 * FRAC_BITS + 1)));

	// Coefficient set for a sector.
	function automatic coef_set_t coef_lookup(input logic [SECTOR_W-1:0] s);
		coef_set_t c;
		unique case (s)
			SECTOR_0: c = '{c0: K_SQ32,  c1: -K_SQH,  c2: '0,      c3: K_SQ2};
			SECTOR_1: c = '{c0: -K_SQ32, c1: K_SQH,   c2: K_SQ32,  c3: K_SQH};
			SECTOR_2: c = '{c0: '0,      c1: K_SQ2,   c2: -K_SQ32, c3: -K_SQH};
			SECTOR_3: c = '{c0: '0,      c1: -K_SQ2,  c2: -K_SQ32, c3: K_SQH};
			SECTOR_4: c = '{c0: -K_SQ32, c1: -K_SQH,  c2: K_SQ32,  c3: -K_SQH};
			SECTOR_5: c = '{c0: K_SQ32,  c1: K_SQH,   c2: '0,      c3: -K_SQ2};
			default:  c = '{c0: K_SQ32,  c1: -K_SQH,  c2: '0,      c3: K_SQ2};
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/svpwm_duty_compare_gen_unit.sv =====
// Space-vector PWM duty and compare generator for a three-phase bridge. Each input item is
// an (alpha, beta) voltage command in signed Q24 plus a stop flag; each result item carries
// the three clamped, inverted and offset duties, the compare values for the configured half
// period, the 60-degree sector and an enable flag that is low when a stop was requested.
// The block sustains one item per clock cycle while in_ready stays high; an accepted item
// passes through the two front classification stages, the four-entry item queue and the
// seven-stage back datapath whose multipliers and adders are each registered.
// A sixteen-entry result queue lets the input side keep running while results wait to be
// taken. Configuration registers are written through the cfg channel, which is always
// ready, and should only be changed while no items are in flight.
`include "svpwm_duty_compare_gen_unit_defines.svh"

module svpwm_duty_compare_gen_unit import svpwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [WORD_W-1:0] alpha,
	input  logic signed [WORD_W-1:0] beta,
	input  logic                     stop_request,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DUTY_W-1:0]        duty_a,
	output logic [DUTY_W-1:0]        duty_b,
	output logic [DUTY_W-1:0]        duty_c,
	output logic [CMP_W-1:0]         compare_a,
	output logic [CMP_W-1:0]         compare_b,
	output logic [CMP_W-1:0]         compare_c,
	output logic [SECTOR_W-1:0]      sector,
	output logic                     outputs_enabled
);

	cfg_regs_t cfg;
	logic      fq_push;
	fq_item_t  fq_item;
	logic      fq_pop;
	fq_stat_t  fq_stat;
	logic      duties_in_range;

	// Configuration registers.
	svpwm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Front: admits items, scales them and finds the sector.
	svpwm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.alpha        (alpha),
		.beta         (beta),
		.stop_request (stop_request),
		.cfg          (cfg),
		.fq_pop       (fq_pop),
		.fq_push      (fq_push),
		.fq_item      (fq_item)
	);

	// Item queue between the two halves.
	svpwm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_item (fq_item),
		.pop       (fq_pop),
		.stat      (fq_stat)
	);

	// Back: switching times, duties, compares and the result queue.
	svpwm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.fq_stat         (fq_stat),
		.fq_pop          (fq_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.duty_a          (duty_a),
		.duty_b          (duty_b),
		.duty_c          (duty_c),
		.compare_a       (compare_a),
		.compare_b       (compare_b),
		.compare_c       (compare_c),
		.sector          (sector),
		.outputs_enabled (outputs_enabled)
	);

	// All three delivered duties lie within zero to one.
	assign duties_in_range = (duty_a <= DUTY_ONE) && (duty_b <= DUTY_ONE) && (duty_c <= DUTY_ONE);

	// Checks on queue handling and on the range of delivered results.
	`SVPWM_ASSERT_SAME(a_pop_nonempty, fq_pop, fq_stat.valid, "item queue popped while empty")
	`SVPWM_ASSERT_NEXT(a_queue_keeps, fq_stat.valid && !fq_pop, fq_stat.valid, "queued item lost")
	`SVPWM_ASSERT_SAME(a_sector_range, out_valid, sector <= SECTOR_MAX, "sector out of range")
	`SVPWM_ASSERT_SAME(a_duty_range, out_valid, duties_in_range, "duty above one")

endmodule

// ===== hdl/svpwm_cfg.sv =====
module svpwm_cfg import svpwm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output cfg_regs_t            cfg
);

	cfg_regs_t cfg_q;
	logic      cfg_write;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	// Register file; the gain is stored as its wrapped magnitude, unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_abs    <= ONE_Q;
			cfg_q.offset_a    <= '0;
			cfg_q.offset_b    <= '0;
			cfg_q.offset_c    <= '0;
			cfg_q.half_period <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DC_GAIN: begin
					cfg_q.gain_abs <= cfg_data[WORD_W-1] ? (~cfg_data + 1'b1) : cfg_data;
				end
				REG_OFFSET_A:    cfg_q.offset_a    <= cfg_data;
				REG_OFFSET_B:    cfg_q.offset_b    <= cfg_data;
				REG_OFFSET_C:    cfg_q.offset_c    <= cfg_data;
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_data[HP_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/svpwm_front.sv =====
module svpwm_front import svpwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [WORD_W-1:0] alpha,
	input  logic signed [WORD_W-1:0] beta,
	input  logic                     stop_request,
	input  cfg_regs_t                cfg,
	input  logic                     fq_pop,
	output logic                     fq_push,
	output fq_item_t                 fq_item
);

	logic                      accept;
	logic [FQ_CNT_W-1:0]       credit_q;
	logic                      valid_s1;
	logic                      valid_s2;
	logic signed [WORD_W-1:0]  alpha_s1;
	logic signed [WORD_W-1:0]  beta_s1;
	logic                      stop_s1;
	logic [WORD_W-1:0]         abs_a;
	logic [WORD_W-1:0]         abs_b;
	logic signed [WORD_W-1:0]  gain;
	logic signed [2*WORD_W-1:0] prod_a;
	logic signed [2*WORD_W-1:0] prod_b;
	logic [2*WORD_W-1:0]       sq_a;
	logic [2*WORD_W-1:0]       sq_b;
	logic [WORD_W-1:0]         ag_s2;
	logic [WORD_W-1:0]         bg_s2;
	logic [2*WORD_W-1:0]       sq_a_s2;
	logic [2*WORD_W-1:0]       sq_b_s2;
	logic                      a_neg_s2;
	logic                      a_zero_s2;
	logic                      b_neg_s2;
	logic                      b_zero_s2;
	logic                      stop_s2;
	logic                      steep;
	logic                      a_pos;
	logic                      b_pos;
	logic [SECTOR_W-1:0]       sector;

	// An item is admitted only when the queue is sure to have room for it.
	assign in_ready = credit_q < FQ_CNT_W'(FQ_DEPTH);
	assign accept   = in_valid && in_ready;

	// Credits count items in the front stages and in the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			credit_q <= credit_q + FQ_CNT_W'(accept) - FQ_CNT_W'(fq_pop);
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1 captures the vector.
	always_ff @(posedge clk) begin
		if (accept) begin
			alpha_s1 <= alpha;
			beta_s1  <= beta;
			stop_s1  <= stop_request;
		end
	end

	// Magnitudes, squares and gain products from stage 1.
	assign gain   = $signed(cfg.gain_abs);
	assign abs_a  = alpha_s1[WORD_W-1] ? (~alpha_s1 + 1'b1) : alpha_s1;
	assign abs_b  = beta_s1[WORD_W-1] ? (~beta_s1 + 1'b1) : beta_s1;
	assign prod_a = alpha_s1 * gain;
	assign prod_b = beta_s1 * gain;
	assign sq_a   = abs_a * abs_a;
	assign sq_b   = abs_b * abs_b;

	// Stage 2 holds the scaled vector and the squared magnitudes.
	always_ff @(posedge clk) begin
		ag_s2     <= prod_a[FRAC_BITS+WORD_W-1:FRAC_BITS];
		bg_s2     <= prod_b[FRAC_BITS+WORD_W-1:FRAC_BITS];
		sq_a_s2   <= sq_a;
		sq_b_s2   <= sq_b;
		a_neg_s2  <= alpha_s1[WORD_W-1];
		a_zero_s2 <= alpha_s1 == '0;
		b_neg_s2  <= beta_s1[WORD_W-1];
		b_zero_s2 <= beta_s1 == '0;
		stop_s2   <= stop_s1;
	end

	// Sector from the signs and from beta squared against three alpha squared.
	assign steep = sq_b_s2 > ((sq_a_s2 << 1) + sq_a_s2);
	assign a_pos = !a_neg_s2 && !a_zero_s2;
	assign b_pos = !b_neg_s2 && !b_zero_s2;

	always_comb begin
		priority if (a_zero_s2 && b_zero_s2) begin
			sector = SECTOR_0;
		end else if (b_pos || (b_zero_s2 && a_pos)) begin
			sector = steep ? SECTOR_1 : (a_pos ? SECTOR_0 : SECTOR_2);
		end else if (b_zero_s2) begin
			sector = SECTOR_3;
		end else begin
			sector = steep ? SECTOR_4 : (a_neg_s2 ? SECTOR_3 : SECTOR_5);
		end
	end

	// Classified item into the queue.
	assign fq_push        = valid_s2;
	assign fq_item.ag     = ag_s2;
	assign fq_item.bg     = bg_s2;
	assign fq_item.sector = sector;
	assign fq_item.stop   = stop_s2;

endmodule

// ===== hdl/svpwm_queue.sv =====
module svpwm_queue import svpwm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  fq_item_t push_item,
	input  logic     pop,
	output fq_stat_t stat
);

	fq_item_t            mem_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_ptr_q;
	logic [FQ_PTR_W-1:0] rd_ptr_q;
	logic [FQ_CNT_W-1:0] count_q;

	// Pointers and fill level; the producer never pushes into a full queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign stat.valid = count_q != '0;
	assign stat.head  = mem_q[rd_ptr_q];

endmodule

// ===== hdl/svpwm_back.sv =====
module svpwm_back import svpwm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_regs_t           cfg,
	input  fq_stat_t            fq_stat,
	output logic                fq_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DUTY_W-1:0]   duty_a,
	output logic [DUTY_W-1:0]   duty_b,
	output logic [DUTY_W-1:0]   duty_c,
	output logic [CMP_W-1:0]    compare_a,
	output logic [CMP_W-1:0]    compare_b,
	output logic [CMP_W-1:0]    compare_c,
	output logic [SECTOR_W-1:0] sector,
	output logic                outputs_enabled
);

	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic                stop;
	} tag_t;

	logic                            out_accept;
	logic [OQ_CNT_W-1:0]             credit_q;
	logic                            valid_s3, valid_s4, valid_s5, valid_s6;
	logic                            valid_s7, valid_s8, valid_s9;
	tag_t                            tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8, tag_s9;
	coef_set_t                       coef_s3;
	logic signed [WORD_W-1:0]        ag_s3;
	logic signed [WORD_W-1:0]        bg_s3;
	logic signed [COEF_W+WORD_W-1:0] prod0, prod1, prod2, prod3;
	logic [WORD_W-1:0]               pr0_s4, pr1_s4, pr2_s4, pr3_s4;
	logic [WORD_W-1:0]               t1_s5, t2_s5;
	logic [WORD_W-1:0]               t0_s6, t1_s6, t2_s6;
	logic [WORD_W-1:0]               d_first, d_second, d_third;
	logic [WORD_W-1:0]               da, db, dc;
	logic [WORD_W-1:0]               da_s7, db_s7, dc_s7;
	logic [WORD_W-1:0]               ra_s8, rb_s8, rc_s8;
	logic [DUTY_W-1:0]               duty_a_s9, duty_b_s9, duty_c_s9;
	logic [HP_W+DUTY_W-1:0]          cmp_a, cmp_b, cmp_c;
	out_item_t                       result;
	out_item_t                       oq_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]             oq_wr_q;
	logic [OQ_PTR_W-1:0]             oq_rd_q;
	logic [OQ_CNT_W-1:0]             oq_count_q;

	// Saturate a wrapped duty to the range zero to one.
	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [WORD_W-1:0] raw);
		logic [DUTY_W-1:0] res;
		if ($signed(raw) > $signed(ONE_Q)) begin
			res = DUTY_ONE;
		end else if (raw[WORD_W-1]) begin
			res = '0;
		end else begin
			res = raw[DUTY_W-1:0];
		end
		return res;
	endfunction

	// An item is taken from the queue only when the result queue has room for it.
	assign fq_pop     = fq_stat.valid && (credit_q < OQ_CNT_W'(OQ_DEPTH));
	assign out_accept = out_valid && out_ready;

	// Valid bits of the stages and the result credit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			credit_q <= credit_q + OQ_CNT_W'(fq_pop) - OQ_CNT_W'(out_accept);
			valid_s3 <= fq_pop;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	// Stage 3 picks up the item and its sector coefficients.
	always_ff @(posedge clk) begin
		if (fq_pop) begin
			coef_s3 <= coef_lookup(fq_stat.head.sector);
			ag_s3   <= $signed(fq_stat.head.ag);
			bg_s3   <= $signed(fq_stat.head.bg);
			tag_s3  <= '{sector: fq_stat.head.sector, stop: fq_stat.head.stop};
		end
	end

	// Stage 4 forms the four coefficient products.
	assign prod0 = coef_s3.c0 * ag_s3;
	assign prod1 = coef_s3.c1 * bg_s3;
	assign prod2 = coef_s3.c2 * ag_s3;
	assign prod3 = coef_s3.c3 * bg_s3;

	always_ff @(posedge clk) begin
		pr0_s4 <= prod0[FRAC_BITS+WORD_W-1:FRAC_BITS];
		pr1_s4 <= prod1[FRAC_BITS+WORD_W-1:FRAC_BITS];
		pr2_s4 <= prod2[FRAC_BITS+WORD_W-1:FRAC_BITS];
		pr3_s4 <= prod3[FRAC_BITS+WORD_W-1:FRAC_BITS];
		tag_s4 <= tag_s3;
	end

	// Stages 5 and 6 give the active times and then the zero time.
	always_ff @(posedge clk) begin
		t1_s5  <= pr0_s4 + pr1_s4;
		t2_s5  <= pr2_s4 + pr3_s4;
		tag_s5 <= tag_s4;
		t0_s6  <= ONE_Q - t1_s5 - t2_s5;
		t1_s6  <= t1_s5;
		t2_s6  <= t2_s5;
		tag_s6 <= tag_s5;
	end

	// Centred duties, handed to the phases in the order the sector sets.
	assign d_first  = {t0_s6[WORD_W-1], t0_s6[WORD_W-1:1]};
	assign d_second = d_first + t1_s6;
	assign d_third  = d_second + t2_s6;

	always_comb begin
		unique case (tag_s6.sector)
			SECTOR_1: begin
				da = d_second; db = d_first;  dc = d_third;
			end
			SECTOR_2: begin
				da = d_third;  db = d_first;  dc = d_second;
			end
			SECTOR_3: begin
				da = d_third;  db = d_second; dc = d_first;
			end
			SECTOR_4: begin
				da = d_second; db = d_third;  dc = d_first;
			end
			SECTOR_5: begin
				da = d_first;  db = d_third;  dc = d_second;
			end
			default: begin
				da = d_first;  db = d_second; dc = d_third;
			end
		endcase
	end

	// Stage 7 registers the phase duties; stage 8 inverts them and adds the offsets.
	always_ff @(posedge clk) begin
		da_s7  <= da;
		db_s7  <= db;
		dc_s7  <= dc;
		tag_s7 <= tag_s6;
		ra_s8  <= ONE_Q - da_s7 + cfg.offset_a;
		rb_s8  <= ONE_Q - db_s7 + cfg.offset_b;
		rc_s8  <= ONE_Q - dc_s7 + cfg.offset_c;
		tag_s8 <= tag_s7;
	end

	// Stage 9 clamps each duty.
	always_ff @(posedge clk) begin
		duty_a_s9 <= clamp_duty(ra_s8);
		duty_b_s9 <= clamp_duty(rb_s8);
		duty_c_s9 <= clamp_duty(rc_s8);
		tag_s9    <= tag_s8;
	end

	// Compare values go straight into the result queue.
	assign cmp_a = cfg.half_period * duty_a_s9;
	assign cmp_b = cfg.half_period * duty_b_s9;
	assign cmp_c = cfg.half_period * duty_c_s9;

	assign result.duty_a    = duty_a_s9;
	assign result.duty_b    = duty_b_s9;
	assign result.duty_c    = duty_c_s9;
	assign result.compare_a = cmp_a[FRAC_BITS+CMP_W-1:FRAC_BITS];
	assign result.compare_b = cmp_b[FRAC_BITS+CMP_W-1:FRAC_BITS];
	assign result.compare_c = cmp_c[FRAC_BITS+CMP_W-1:FRAC_BITS];
	assign result.sector    = tag_s9.sector;
	assign result.enabled   = !tag_s9.stop;

	// Result queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_count_q <= '0;
		end else begin
			if (valid_s9) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (out_accept) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_count_q <= oq_count_q + OQ_CNT_W'(valid_s9) - OQ_CNT_W'(out_accept);
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (valid_s9) begin
			oq_q[oq_wr_q] <= result;
		end
	end

	// Head of the result queue drives the output channel.
	assign out_valid       = oq_count_q != '0;
	assign duty_a          = oq_q[oq_rd_q].duty_a;
	assign duty_b          = oq_q[oq_rd_q].duty_b;
	assign duty_c          = oq_q[oq_rd_q].duty_c;
	assign compare_a       = oq_q[oq_rd_q].compare_a;
	assign compare_b       = oq_q[oq_rd_q].compare_b;
	assign compare_c       = oq_q[oq_rd_q].compare_c;
	assign sector          = oq_q[oq_rd_q].sector;
	assign outputs_enabled = oq_q[oq_rd_q].enabled;

endmodule
